// File: hw/rtl/acpu_pkg.sv
// Package for the accumulator processor: payload types, opcodes and address constants.
package acpu_pkg;

    localparam int MEM_WORDS_DEF = 2000;

    localparam logic [31:0] SYS_BASE      = 32'd1000;
    localparam logic [31:0] TIMER_VECTOR  = 32'd1000;
    localparam logic [31:0] SYSCALL_ENTRY = 32'd1500;
    localparam logic [31:0] STACK_TOP     = 32'd2000;
    localparam logic [31:0] USER_SP_RESET = 32'd1000;
    localparam logic [15:0] PERIOD_RESET  = 16'd100;

    localparam logic [31:0] OP_LDI   = 32'd1;
    localparam logic [31:0] OP_LDD   = 32'd2;
    localparam logic [31:0] OP_LDN   = 32'd3;
    localparam logic [31:0] OP_LDX   = 32'd4;
    localparam logic [31:0] OP_LDY   = 32'd5;
    localparam logic [31:0] OP_LDSPX = 32'd6;
    localparam logic [31:0] OP_ST    = 32'd7;
    localparam logic [31:0] OP_RND   = 32'd8;
    localparam logic [31:0] OP_PUT   = 32'd9;
    localparam logic [31:0] OP_ADDX  = 32'd10;
    localparam logic [31:0] OP_ADDY  = 32'd11;
    localparam logic [31:0] OP_SUBX  = 32'd12;
    localparam logic [31:0] OP_SUBY  = 32'd13;
    localparam logic [31:0] OP_CPTX  = 32'd14;
    localparam logic [31:0] OP_CPFX  = 32'd15;
    localparam logic [31:0] OP_CPTY  = 32'd16;
    localparam logic [31:0] OP_CPFY  = 32'd17;
    localparam logic [31:0] OP_CPTSP = 32'd18;
    localparam logic [31:0] OP_CPFSP = 32'd19;
    localparam logic [31:0] OP_JMP   = 32'd20;
    localparam logic [31:0] OP_JZ    = 32'd21;
    localparam logic [31:0] OP_JNZ   = 32'd22;
    localparam logic [31:0] OP_CALL  = 32'd23;
    localparam logic [31:0] OP_RET   = 32'd24;
    localparam logic [31:0] OP_INCX  = 32'd25;
    localparam logic [31:0] OP_DECX  = 32'd26;
    localparam logic [31:0] OP_PUSH  = 32'd27;
    localparam logic [31:0] OP_POP   = 32'd28;
    localparam logic [31:0] OP_SYS   = 32'd29;
    localparam logic [31:0] OP_IRET  = 32'd30;
    localparam logic [31:0] OP_END   = 32'd50;

    localparam logic ITEM_LOAD = 1'b0;
    localparam logic ITEM_EXEC = 1'b1;

    localparam logic [2:0] REG_TIMER_PERIOD = 3'd0;

    typedef struct packed {
        logic               op;
        logic [10:0]        load_address;
        logic signed [31:0] load_data;
        logic [6:0]         random_value;
    } in_t;

    typedef struct packed {
        logic               put_valid;
        logic signed [31:0] put_value;
        logic               put_as_number;
        logic               halted;
        logic               violation;
        logic [10:0]        program_counter;
    } out_t;

    // Legal access: inside memory, and below system memory unless in kernel mode.
    function automatic logic addr_ok(input logic [31:0] a, input logic kern,
                                     input logic [31:0] words);
        addr_ok = (a < words) && (kern || (a < SYS_BASE));
    endfunction

endpackage

// File: hw/rtl/acpu_mem.sv
// Single-port word memory of the processor with a registered read.
module acpu_mem #(
    parameter int WORDS = acpu_pkg::MEM_WORDS_DEF,
    parameter int AW    = $clog2(WORDS)
) (
    input  logic          clk,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [31:0]   wdata,
    output logic [31:0]   rdata
);

    logic [31:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

// File: hw/rtl/accumulator_cpu_with_timer_irq.sv
// Top level of the accumulator processor: sequencer, registers, timer and APB port.
//
// A load beat writes one word into the private memory in the cycle it is accepted. An execute
// beat runs one instruction and yields one result beat; every memory access of that instruction
// (the fetch, up to three operand reads, a store or push, and the two stack writes of a system
// call or timer interrupt) goes in turn through the single memory port, one per cycle. The
// block takes no new beat while an instruction is in progress. Every instruction access but the
// stack writes of a system call or timer interrupt is checked: in user mode an address of 1000
// or more, and in any mode an address beyond the memory, halts the block with the violation
// flag set and leaves the registers as they were before the instruction. Once halted, execute
// beats return the halted state and load beats still write memory. The timer period register
// lies at byte address 0 of the APB port.
module accumulator_cpu_with_timer_irq #(
    parameter int MEM_WORDS = acpu_pkg::MEM_WORDS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  acpu_pkg::in_t    in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output acpu_pkg::out_t   out_data,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int          AW    = $clog2(MEM_WORDS);
    localparam logic [31:0] WORDS = 32'(MEM_WORDS);

    // One-hot sequencer states.
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_FETCH = 10'b0000000010,
        S_DEC   = 10'b0000000100,
        S_R1    = 10'b0000001000,
        S_R2    = 10'b0000010000,
        S_R3    = 10'b0000100000,
        S_W2    = 10'b0001000000,
        S_FIN   = 10'b0010000000,
        S_IRQ   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // Architectural state, updated only when an instruction completes; the timer period is written from APB.
    logic [31:0] pc_reg, pc_next, sp_reg, sp_next, ac_reg, ac_next;
    logic [31:0] x_reg, x_next, y_reg, y_next, cnt_reg, cnt_next;
    logic        irq_reg, irq_next, kern_reg, kern_next;
    logic [1:0]  stop_reg, stop_next;
    logic [15:0] period_reg, period_next;

    // Working copies for the instruction in progress.
    logic [31:0] pcw_reg, pcw_next, spw_reg, spw_next, acw_reg, acw_next;
    logic [31:0] xw_reg, xw_next, yw_reg, yw_next, ir_reg, ir_next, t_reg, t_next;
    logic        kernw_reg, kernw_next, irqw_reg, irqw_next, iret_reg, iret_next;
    logic [6:0]  rand_reg, rand_next;
    logic        putv_reg, putv_next, putn_reg, putn_next;
    logic [31:0] putd_reg, putd_next;

    logic           out_valid_reg, out_valid_next;
    acpu_pkg::out_t out_data_reg, out_data_next;

    // Memory port and the shared address adder.
    logic        mem_req, mem_we, mem_chk, fault;
    logic [31:0] addr_base, addr_off, mem_addr, mem_wdata, mem_q;

    logic        in_fire, cfg_wr;
    logic [31:0] cnt_inc, period_eff;
    logic        take_irq;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && (paddr == acpu_pkg::REG_TIMER_PERIOD);
    assign prdata    = (paddr == acpu_pkg::REG_TIMER_PERIOD) ? {16'b0, period_reg} : 32'b0;

    assign mem_addr = addr_base + addr_off;
    assign fault    = mem_req && mem_chk && !acpu_pkg::addr_ok(mem_addr, kernw_reg, WORDS);

    assign cnt_inc    = (cnt_reg == 32'hFFFF_FFFF) ? cnt_reg : cnt_reg + 32'd1;
    assign period_eff = (period_reg == 16'd0) ? 32'd1 : {16'b0, period_reg};
    assign take_irq   = (cnt_inc >= period_eff) && irqw_reg && !iret_reg;

    acpu_mem #(
        .WORDS (MEM_WORDS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .en    (mem_req && !fault),
        .we    (mem_we),
        .addr  (mem_addr[AW-1:0]),
        .wdata (mem_wdata),
        .rdata (mem_q)
    );

    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        sp_next     = sp_reg;
        ac_next     = ac_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        cnt_next    = cnt_reg;
        irq_next    = irq_reg;
        kern_next   = kern_reg;
        stop_next   = stop_reg;
        period_next = cfg_wr ? pwdata[15:0] : period_reg;
        pcw_next    = pcw_reg;
        spw_next    = spw_reg;
        acw_next    = acw_reg;
        xw_next     = xw_reg;
        yw_next     = yw_reg;
        ir_next     = ir_reg;
        t_next      = t_reg;
        kernw_next  = kernw_reg;
        irqw_next   = irqw_reg;
        iret_next   = iret_reg;
        rand_next   = rand_reg;
        putv_next   = putv_reg;
        putn_next   = putn_reg;
        putd_next   = putd_reg;
        mem_req     = 1'b0;
        mem_we      = 1'b0;
        mem_chk     = 1'b1;
        addr_base   = pcw_reg;
        addr_off    = 32'd0;
        mem_wdata   = acw_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    putv_next = 1'b0;
                    putn_next = 1'b0;
                    putd_next = 32'd0;
                    if (in_data.op == acpu_pkg::ITEM_LOAD)
                    begin
                        mem_chk   = 1'b0;
                        mem_we    = 1'b1;
                        addr_base = 32'(in_data.load_address);
                        mem_wdata = in_data.load_data;
                        mem_req   = (addr_base < WORDS);
                    end
                    else if (stop_reg[0])
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        pcw_next   = pc_reg;
                        spw_next   = sp_reg;
                        acw_next   = ac_reg;
                        xw_next    = x_reg;
                        yw_next    = y_reg;
                        kernw_next = kern_reg;
                        irqw_next  = irq_reg;
                        iret_next  = 1'b0;
                        rand_next  = in_data.random_value;
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                mem_req    = 1'b1;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                ir_next    = mem_q;
                state_next = S_FIN;
                case (mem_q)
                    acpu_pkg::OP_LDI, acpu_pkg::OP_LDD, acpu_pkg::OP_LDN,
                    acpu_pkg::OP_LDX, acpu_pkg::OP_LDY, acpu_pkg::OP_ST,
                    acpu_pkg::OP_PUT, acpu_pkg::OP_JMP, acpu_pkg::OP_CALL:
                    begin
                        mem_req    = 1'b1;
                        addr_off   = 32'd1;
                        state_next = S_R1;
                    end
                    acpu_pkg::OP_JZ, acpu_pkg::OP_JNZ:
                    begin
                        if ((acw_reg == 32'd0) == (mem_q == acpu_pkg::OP_JZ))
                        begin
                            mem_req    = 1'b1;
                            addr_off   = 32'd1;
                            state_next = S_R1;
                        end
                        else
                        begin
                            pcw_next = pcw_reg + 32'd2;
                        end
                    end
                    acpu_pkg::OP_LDSPX:
                    begin
                        mem_req    = 1'b1;
                        addr_base  = spw_reg;
                        addr_off   = xw_reg;
                        state_next = S_R1;
                    end
                    acpu_pkg::OP_RET, acpu_pkg::OP_POP, acpu_pkg::OP_IRET:
                    begin
                        mem_req    = 1'b1;
                        addr_base  = spw_reg;
                        state_next = S_R1;
                    end
                    acpu_pkg::OP_PUSH:
                    begin
                        mem_req   = 1'b1;
                        mem_we    = 1'b1;
                        addr_base = spw_reg;
                        addr_off  = 32'hFFFF_FFFF;
                        spw_next  = mem_addr;
                        pcw_next  = pcw_reg + 32'd1;
                    end
                    acpu_pkg::OP_SYS:
                    begin
                        // Stack writes of a system call are not checked, so they cannot fault.
                        mem_req    = 1'b1;
                        mem_we     = 1'b1;
                        mem_chk    = 1'b0;
                        addr_base  = acpu_pkg::STACK_TOP;
                        addr_off   = 32'hFFFF_FFFF;
                        mem_wdata  = spw_reg;
                        kernw_next = 1'b1;
                        irqw_next  = 1'b0;
                        state_next = S_W2;
                    end
                    acpu_pkg::OP_RND:
                    begin
                        acw_next = 32'(rand_reg);
                        pcw_next = pcw_reg + 32'd1;
                    end
                    acpu_pkg::OP_ADDX:
                    begin
                        acw_next = acw_reg + xw_reg;
                        pcw_next = pcw_reg + 32'd1;
                    end
                    acpu_pkg::OP_ADDY:
                    begin
                        acw_next = acw_reg + yw_reg;
                        pcw_next = pcw_reg + 32'd1;
                    end
                    acpu_pkg::OP_SUBX:
                    begin
                        acw_next = acw_reg - xw_reg;
                        pcw_next = pcw_reg + 32'd1;
                    end
                    acpu_pkg::OP_SUBY:
                    begin
                        acw_next = acw_reg - yw_reg;
                        pcw_next = pcw_reg + 32'd1;
                    end
                    acpu_pkg::OP_CPTX:
                    begin
                        xw_next  = acw_reg;
                        pcw_next = pcw_reg + 32'd1;
                    end
                    acpu_pkg::OP_CPFX:
                    begin
                        acw_next = xw_reg;
                        pcw_next = pcw_reg + 32'd1;
                    end
                    acpu_pkg::OP_CPTY:
                    begin
                        yw_next  = acw_reg;
                        pcw_next = pcw_reg + 32'd1;
                    end
                    acpu_pkg::OP_CPFY:
                    begin
                        acw_next = yw_reg;
                        pcw_next = pcw_reg + 32'd1;
                    end
                    acpu_pkg::OP_CPTSP:
                    begin
                        spw_next = acw_reg;
                        pcw_next = pcw_reg + 32'd1;
                    end
                    acpu_pkg::OP_CPFSP:
                    begin
                        acw_next = spw_reg;
                        pcw_next = pcw_reg + 32'd1;
                    end
                    acpu_pkg::OP_INCX:
                    begin
                        xw_next  = xw_reg + 32'd1;
                        pcw_next = pcw_reg + 32'd1;
                    end
                    acpu_pkg::OP_DECX:
                    begin
                        xw_next  = xw_reg - 32'd1;
                        pcw_next = pcw_reg + 32'd1;
                    end
                    acpu_pkg::OP_END:
                    begin
                        stop_next  = 2'b01;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        pcw_next = pcw_reg + 32'd1;
                    end
                endcase
            end
            S_R1:
            begin
                state_next = S_FIN;
                case (ir_reg)
                    acpu_pkg::OP_LDI:
                    begin
                        acw_next = mem_q;
                        pcw_next = pcw_reg + 32'd2;
                    end
                    acpu_pkg::OP_LDD, acpu_pkg::OP_LDN, acpu_pkg::OP_LDX, acpu_pkg::OP_LDY:
                    begin
                        mem_req    = 1'b1;
                        addr_base  = mem_q;
                        addr_off   = (ir_reg == acpu_pkg::OP_LDX) ? xw_reg :
                                     (ir_reg == acpu_pkg::OP_LDY) ? yw_reg : 32'd0;
                        state_next = S_R2;
                    end
                    acpu_pkg::OP_LDSPX:
                    begin
                        acw_next = mem_q;
                        pcw_next = pcw_reg + 32'd1;
                    end
                    acpu_pkg::OP_ST:
                    begin
                        mem_req   = 1'b1;
                        mem_we    = 1'b1;
                        addr_base = mem_q;
                        pcw_next  = pcw_reg + 32'd2;
                    end
                    acpu_pkg::OP_PUT:
                    begin
                        putv_next = 1'b1;
                        putd_next = acw_reg;
                        putn_next = (mem_q == 32'd1);
                        pcw_next  = pcw_reg + 32'd2;
                    end
                    acpu_pkg::OP_CALL:
                    begin
                        mem_req   = 1'b1;
                        mem_we    = 1'b1;
                        addr_base = spw_reg;
                        addr_off  = 32'hFFFF_FFFF;
                        mem_wdata = pcw_reg + 32'd2;
                        spw_next  = mem_addr;
                        pcw_next  = mem_q;
                    end
                    acpu_pkg::OP_RET:
                    begin
                        pcw_next = mem_q;
                        spw_next = spw_reg + 32'd1;
                    end
                    acpu_pkg::OP_POP:
                    begin
                        acw_next = mem_q;
                        spw_next = spw_reg + 32'd1;
                        pcw_next = pcw_reg + 32'd1;
                    end
                    acpu_pkg::OP_IRET:
                    begin
                        t_next     = mem_q;
                        mem_req    = 1'b1;
                        addr_base  = spw_reg;
                        addr_off   = 32'd1;
                        state_next = S_R2;
                    end
                    default:
                    begin
                        // Jumps that read their target.
                        pcw_next = mem_q;
                    end
                endcase
            end
            S_R2:
            begin
                state_next = S_FIN;
                if (ir_reg == acpu_pkg::OP_LDN)
                begin
                    mem_req    = 1'b1;
                    addr_base  = mem_q;
                    state_next = S_R3;
                end
                else if (ir_reg == acpu_pkg::OP_IRET)
                begin
                    pcw_next   = t_reg;
                    spw_next   = mem_q;
                    irqw_next  = 1'b1;
                    kernw_next = 1'b0;
                    iret_next  = 1'b1;
                end
                else
                begin
                    acw_next = mem_q;
                    pcw_next = pcw_reg + 32'd2;
                end
            end
            S_R3:
            begin
                acw_next   = mem_q;
                pcw_next   = pcw_reg + 32'd2;
                state_next = S_FIN;
            end
            S_W2:
            begin
                mem_req    = 1'b1;
                mem_we     = 1'b1;
                mem_chk    = 1'b0;
                addr_base  = acpu_pkg::STACK_TOP;
                addr_off   = 32'hFFFF_FFFE;
                mem_wdata  = pcw_reg + 32'd1;
                spw_next   = mem_addr;
                pcw_next   = acpu_pkg::SYSCALL_ENTRY;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (take_irq)
                begin
                    mem_req    = 1'b1;
                    mem_we     = 1'b1;
                    mem_chk    = 1'b0;
                    addr_base  = acpu_pkg::STACK_TOP;
                    addr_off   = 32'hFFFF_FFFF;
                    mem_wdata  = spw_reg;
                    cnt_next   = cnt_inc - period_eff;
                    state_next = S_IRQ;
                end
                else
                begin
                    pc_next    = pcw_reg;
                    sp_next    = spw_reg;
                    ac_next    = acw_reg;
                    x_next     = xw_reg;
                    y_next     = yw_reg;
                    irq_next   = irqw_reg;
                    kern_next  = kernw_reg;
                    cnt_next   = cnt_inc;
                    if (!acpu_pkg::addr_ok(pcw_reg, kernw_reg, WORDS))
                    begin
                        stop_next = 2'b11;
                    end
                    state_next = S_DONE;
                end
            end
            S_IRQ:
            begin
                mem_req    = 1'b1;
                mem_we     = 1'b1;
                mem_chk    = 1'b0;
                addr_base  = acpu_pkg::STACK_TOP;
                addr_off   = 32'hFFFF_FFFE;
                mem_wdata  = pcw_reg;
                pc_next    = acpu_pkg::TIMER_VECTOR;
                sp_next    = mem_addr;
                ac_next    = acw_reg;
                x_next     = xw_reg;
                y_next     = yw_reg;
                irq_next   = 1'b0;
                kern_next  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.put_valid       = putv_reg;
                    out_data_next.put_value       = putd_reg;
                    out_data_next.put_as_number   = putn_reg;
                    out_data_next.halted          = stop_reg[0];
                    out_data_next.violation       = stop_reg[1];
                    out_data_next.program_counter = pc_reg[10:0];
                    state_next                    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A refused access ends the instruction with nothing committed.
        if (fault)
        begin
            stop_next  = 2'b11;
            putv_next  = 1'b0;
            putn_next  = 1'b0;
            putd_next  = 32'd0;
            state_next = S_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= 32'd0;
            sp_reg        <= acpu_pkg::USER_SP_RESET;
            ac_reg        <= 32'd0;
            x_reg         <= 32'd0;
            y_reg         <= 32'd0;
            cnt_reg       <= 32'd0;
            irq_reg       <= 1'b1;
            kern_reg      <= 1'b0;
            stop_reg      <= 2'b00;
            period_reg    <= acpu_pkg::PERIOD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            sp_reg        <= sp_next;
            ac_reg        <= ac_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            cnt_reg       <= cnt_next;
            irq_reg       <= irq_next;
            kern_reg      <= kern_next;
            stop_reg      <= stop_next;
            period_reg    <= period_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pcw_reg      <= pcw_next;
        spw_reg      <= spw_next;
        acw_reg      <= acw_next;
        xw_reg       <= xw_next;
        yw_reg       <= yw_next;
        ir_reg       <= ir_next;
        t_reg        <= t_next;
        kernw_reg    <= kernw_next;
        irqw_reg     <= irqw_next;
        iret_reg     <= iret_next;
        rand_reg     <= rand_next;
        putv_reg     <= putv_next;
        putn_reg     <= putn_next;
        putd_reg     <= putd_next;
        out_data_reg <= out_data_next;
    end

endmodule
